### rtl/core/seven_segment_scan_formatter_defines.svh
// assertion macros shared by the seven-segment scan formatter rtl
`ifndef SEVEN_SEGMENT_SCAN_FORMATTER_DEFINES_SVH
`define SEVEN_SEGMENT_SCAN_FORMATTER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SVSF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define SVSF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/svsf_pkg.sv
// types, constants and glyph table of the seven-segment scan formatter
`timescale 1ns / 1ps

package svsf_pkg;

    localparam int DIGITS     = 8;
    localparam int SCAN_W     = $clog2(DIGITS);
    localparam int VOLT_W     = 10;
    localparam int FREQ_W     = 20;
    localparam int SEG_W      = 8;
    localparam int CELLS      = 6;
    localparam int CONV_STEPS = FREQ_W;
    localparam int COUNT_W    = $clog2(CONV_STEPS);
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;

    localparam logic [SEG_W-1:0]  GLYPH_U     = 8'hC1;
    localparam logic [SEG_W-1:0]  GLYPH_F     = 8'h8E;
    localparam logic [SEG_W-1:0]  GLYPH_BLANK = 8'hFF;
    localparam logic [SEG_W-1:0]  DP_MASK     = 8'h7F;
    localparam logic [FREQ_W-1:0] FREQ_MAX    = 20'd999999;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DISPLAY_ON = 1'b0,
        CFG_SHOW_MODE  = 1'b1
    } cfg_index_t;

    typedef enum logic {
        OP_SCAN    = 1'b0,
        OP_REFRESH = 1'b1
    } op_t;

    typedef enum logic {
        MODE_VOLT = 1'b0,
        MODE_FREQ = 1'b1
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_LOAD = 3'b100
    } state_t;

    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctrl_t;

    function automatic logic [SEG_W-1:0] digit_glyph(input logic [3:0] d);
        logic [SEG_W-1:0] g;
        case (d)
            4'd0:    g = 8'hC0;
            4'd1:    g = 8'hF9;
            4'd2:    g = 8'hA4;
            4'd3:    g = 8'hB0;
            4'd4:    g = 8'h99;
            4'd5:    g = 8'h92;
            4'd6:    g = 8'h82;
            4'd7:    g = 8'hF8;
            4'd8:    g = 8'h80;
            4'd9:    g = 8'h90;
            default: g = GLYPH_BLANK;
        endcase
        return g;
    endfunction

endpackage

### rtl/core/svsf_item_if.sv
// input channel: scan tick or refresh word with the display values
`timescale 1ns / 1ps

interface svsf_item_if;
    import svsf_pkg::*;

    logic              valid;
    logic              ready;
    logic              operation;
    logic [VOLT_W-1:0] volt_value;
    logic [FREQ_W-1:0] freq_value;
    logic              half_second_flag;

    modport source (
        output valid, operation, volt_value, freq_value, half_second_flag,
        input  ready
    );

    modport sink (
        input  valid, operation, volt_value, freq_value, half_second_flag,
        output ready
    );
endinterface

### rtl/core/svsf_result_if.sv
// output channel: digit select and active-low segment word
`timescale 1ns / 1ps

interface svsf_result_if;
    import svsf_pkg::*;

    logic              valid;
    logic              ready;
    logic [DIGITS-1:0] digit_select;
    logic [SEG_W-1:0]  segment_pattern;

    modport source (
        output valid, digit_select, segment_pattern,
        input  ready
    );

    modport sink (
        input  valid, digit_select, segment_pattern,
        output ready
    );
endinterface

### rtl/core/svsf_bcd_cell.sv
// one decimal digit cell of the shift-and-add-3 binary to bcd chain
`timescale 1ns / 1ps

module svsf_bcd_cell (
    input  logic                clk,
    input  svsf_pkg::cell_ctrl_t ctrl,
    input  logic                carry_in,
    output logic                carry_out,
    output logic [3:0]          digit
);
    import svsf_pkg::*;

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;

    assign adj       = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
    assign carry_out = adj[3];
    assign digit     = digit_reg;

    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = 4'd0;
        end
        else if (ctrl.shift)
        begin
            digit_next = {adj[2:0], carry_in};
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end
endmodule

### rtl/core/seven_segment_scan_formatter.sv
// Eight-digit multiplexed seven-segment scan formatter. A scan word (operation 0) returns
// one result word: the one-hot select of the current digit and its active-low segment
// byte, then moves to the next digit; scan words are taken one per clock, and a result
// sits in an output register whose stall holds ready low. A refresh word (operation 1)
// returns nothing; it blanks the buffer at once when the display is off, leaves it alone
// in frequency mode without the half-second flag, and otherwise converts the value to
// decimal through a chain of six bcd cells, one bit per clock. Such a refresh holds
// ready low through the shift steps of ST_CONV and the buffer load of ST_LOAD, so the
// next word is taken only once it is done. Configuration writes land in the next cycle.
`timescale 1ns / 1ps
`include "seven_segment_scan_formatter_defines.svh"

module seven_segment_scan_formatter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [svsf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [svsf_pkg::CFG_DATA_W-1:0] cfg_data,
    svsf_item_if.sink                      item,
    svsf_result_if.source                  result
);
    import svsf_pkg::*;

    logic                    display_on_reg;
    logic                    show_mode_reg;
    state_t                  state_reg, state_next;
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic [FREQ_W-1:0]       val_reg, val_next;
    mode_t                   mode_reg, mode_next;
    logic [SEG_W-1:0]        buf_reg [DIGITS];
    logic [SEG_W-1:0]        buf_next [DIGITS];
    logic [SCAN_W-1:0]       scan_reg, scan_next;
    logic                    out_valid_reg, out_valid_next;
    logic [DIGITS-1:0]       sel_reg, sel_next;
    logic [SEG_W-1:0]        seg_reg, seg_next;

    logic                    fire;
    logic                    scan_fire;
    logic                    refresh_fire;
    logic                    conv_start;
    logic [FREQ_W-1:0]       freq_sat;
    cell_ctrl_t              cell_ctrl;
    logic [3:0]              digit [CELLS];
    logic                    carry [CELLS];
    logic                    lit [CELLS];

    // handshake
    assign item.ready   = (state_reg == ST_IDLE) && (!out_valid_reg || result.ready);
    assign fire         = item.valid && item.ready;
    assign scan_fire    = fire && (op_t'(item.operation) == OP_SCAN);
    assign refresh_fire = fire && (op_t'(item.operation) == OP_REFRESH);
    assign conv_start   = refresh_fire && display_on_reg
                          && ((mode_t'(show_mode_reg) == MODE_VOLT) || item.half_second_flag);

    assign result.valid           = out_valid_reg;
    assign result.digit_select    = sel_reg;
    assign result.segment_pattern = seg_reg;

    assign freq_sat = (item.freq_value > FREQ_MAX) ? FREQ_MAX : item.freq_value;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_on_reg <= 1'b1;
            show_mode_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_DISPLAY_ON: display_on_reg <= cfg_data[0];
                CFG_SHOW_MODE:  show_mode_reg  <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // conversion sequencer
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        val_next   = val_reg;
        mode_next  = mode_reg;
        cell_ctrl  = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (conv_start)
                begin
                    state_next      = ST_CONV;
                    count_next      = '0;
                    mode_next       = mode_t'(show_mode_reg);
                    val_next        = (mode_t'(show_mode_reg) == MODE_VOLT)
                                      ? FREQ_W'(item.volt_value) : freq_sat;
                    cell_ctrl.clear = 1'b1;
                end
            end
            ST_CONV:
            begin
                cell_ctrl.shift = 1'b1;
                val_next        = {val_reg[FREQ_W-2:0], 1'b0};
                count_next      = count_reg + COUNT_W'(1);
                if (count_reg == COUNT_W'(CONV_STEPS - 1))
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        mode_reg <= mode_next;
    end

    // bcd cell chain, cell 0 holds the units digit
    genvar gi;
    generate
        for (gi = 0; gi < CELLS; gi++)
        begin : g_cell
            logic cin;
            if (gi == 0)
            begin : g_first
                assign cin = val_reg[FREQ_W-1];
            end
            else
            begin : g_rest
                assign cin = carry[gi-1];
            end
            svsf_bcd_cell u_cell (
                .clk       (clk),
                .ctrl      (cell_ctrl),
                .carry_in  (cin),
                .carry_out (carry[gi]),
                .digit     (digit[gi])
            );
        end
    endgenerate

    // leading-zero blanking: a digit shows once any digit at or above it is nonzero; the units digit always shows
    always_comb
    begin
        for (int j = CELLS - 1; j >= 0; j--)
        begin
            if (j == CELLS - 1)
            begin
                lit[j] = (digit[j] != 4'd0);
            end
            else
            begin
                lit[j] = lit[j+1] || (digit[j] != 4'd0) || (j == 0);
            end
        end
    end

    // segment buffer
    always_comb
    begin
        for (int k = 0; k < DIGITS; k++)
        begin
            buf_next[k] = buf_reg[k];
        end
        if (refresh_fire && !display_on_reg)
        begin
            for (int k = 0; k < DIGITS; k++)
            begin
                buf_next[k] = GLYPH_BLANK;
            end
        end
        else if (state_reg == ST_LOAD)
        begin
            if (mode_reg == MODE_VOLT)
            begin
                buf_next[0] = GLYPH_U;
                for (int k = 1; k < 5; k++)
                begin
                    buf_next[k] = GLYPH_BLANK;
                end
                buf_next[5] = digit_glyph(digit[2]) & DP_MASK;
                buf_next[6] = digit_glyph(digit[1]);
                buf_next[7] = digit_glyph(digit[0]);
            end
            else
            begin
                buf_next[0] = GLYPH_F;
                buf_next[1] = GLYPH_BLANK;
                for (int j = 0; j < CELLS; j++)
                begin
                    buf_next[DIGITS-1-j] = lit[j] ? digit_glyph(digit[j]) : GLYPH_BLANK;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIGITS; k++)
            begin
                buf_reg[k] <= GLYPH_BLANK;
            end
        end
        else
        begin
            for (int k = 0; k < DIGITS; k++)
            begin
                buf_reg[k] <= buf_next[k];
            end
        end
    end

    // scan and output register
    always_comb
    begin
        scan_next      = scan_reg;
        sel_next       = sel_reg;
        seg_next       = seg_reg;
        out_valid_next = out_valid_reg && !result.ready;
        if (scan_fire)
        begin
            scan_next      = scan_reg + SCAN_W'(1);
            sel_next       = DIGITS'(1) << scan_reg;
            seg_next       = buf_reg[scan_reg];
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg <= sel_next;
        seg_reg <= seg_next;
    end

    `SVSF_ASSERT_NOW(a_busy_blocks_input, state_reg != ST_IDLE, !item.ready, "ready while converting")
    `SVSF_ASSERT_NEXT(a_conv_starts, conv_start, state_reg == ST_CONV, "refresh did not start conversion")
    `SVSF_ASSERT_NOW(a_no_bcd_overflow, state_reg == ST_CONV, !carry[CELLS-1], "bcd chain overflow")
    `SVSF_ASSERT_NEXT(a_scan_advances, scan_fire, scan_reg == $past(scan_reg) + SCAN_W'(1), "scan index did not advance")
    `SVSF_ASSERT_NOW(a_select_onehot, out_valid_reg, $onehot(sel_reg), "digit select not one-hot")
endmodule
